[src/phase_current_offset_calibrate_assert.svh]
// Assertion macros shared by the current-sense offset calibration modules.
// Every macro samples on clk and is switched off while rst_n is low.
`ifndef PHASE_CURRENT_OFFSET_CALIBRATE_ASSERT_SVH
`define PHASE_CURRENT_OFFSET_CALIBRATE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define PCOC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define PCOC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/pcoc_pkg.sv]
package pcoc_pkg;

  // Request opcodes.
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_PAIR = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIDSCALE   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN       = 2'd3;

  // Measured phase pairs.
  localparam logic [1:0] PAIR_AB = 2'd0;
  localparam logic [1:0] PAIR_AC = 2'd1;
  localparam logic [1:0] PAIR_BC = 2'd2;

  localparam int CODE_W     = 12;
  localparam int GAIN_W     = 16;
  localparam int GAIN_SHIFT = 12;
  localparam int CUR_W      = 16;
  localparam int SAT_IN_W   = 24;

  localparam logic [1:0]              PAIR_RST     = PAIR_AB;
  localparam logic [CODE_W-1:0]       MIDSCALE_RST = 12'd2048;
  localparam logic [CODE_W-1:0]       TOL_RST      = 12'd200;
  localparam logic signed [GAIN_W-1:0] GAIN_RST    = 16'sd4096;

  typedef enum logic [1:0] {
    KIND_CAL,
    KIND_CLOSE,
    KIND_NORMAL
  } item_kind_t;

  typedef struct packed {
    logic       valid;
    item_kind_t kind;
    logic       fault;
  } stage_ctl_t;

  localparam logic signed [SAT_IN_W-1:0] CUR_MAX = SAT_IN_W'(32767);
  localparam logic signed [SAT_IN_W-1:0] CUR_MIN = SAT_IN_W'(-32768);

  function automatic logic signed [CUR_W-1:0] sat_cur(input logic signed [SAT_IN_W-1:0] v);
    logic signed [CUR_W-1:0] r;
    if (v > CUR_MAX) begin
      r = CUR_MAX[CUR_W-1:0];
    end else if (v < CUR_MIN) begin
      r = CUR_MIN[CUR_W-1:0];
    end else begin
      r = v[CUR_W-1:0];
    end
    return r;
  endfunction

endpackage

[src/pcoc_cal.sv]
`include "phase_current_offset_calibrate_assert.svh"

module pcoc_cal #(
  parameter int ADC_BITS   = 12,
  parameter int AVG_SHIFT  = 7,
  parameter int SKIP_COUNT = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic                                in_op,
  input  logic [ADC_BITS-1:0]                 in_sample_first,
  input  logic [ADC_BITS-1:0]                 in_sample_second,
  input  logic [pcoc_pkg::CODE_W-1:0]         midscale,
  input  logic [pcoc_pkg::CODE_W-1:0]         tolerance,
  input  logic                                s1_take,
  output pcoc_pkg::stage_ctl_t                ctl1,
  output logic signed [ADC_BITS:0]            diff_first,
  output logic signed [ADC_BITS:0]            diff_second
);
  import pcoc_pkg::*;

  localparam int ACC_W  = ADC_BITS + AVG_SHIFT;
  localparam int SKIP_W = (SKIP_COUNT > 0) ? $clog2(SKIP_COUNT + 1) : 1;
  localparam int CNT_W  = AVG_SHIFT + 1;
  localparam int DIFF_W = ADC_BITS + 1;
  localparam int CMP_W  = ACC_W + 2;
  localparam logic [SKIP_W-1:0] SKIP_INIT  = SKIP_W'(SKIP_COUNT);
  localparam logic [CNT_W-1:0]  CNT_INIT   = {1'b1, {AVG_SHIFT{1'b0}}};
  localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(2 ** (AVG_SHIFT - 1));
  localparam logic [ACC_W-1:0]  OFFSET_RST = ACC_W'(2 ** (ADC_BITS - 1));

  logic              busy_r, busy_nxt;
  logic [SKIP_W-1:0] skip_r, skip_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ACC_W-1:0]  off1_r, off1_nxt;
  logic [ACC_W-1:0]  off2_r, off2_nxt;
  stage_ctl_t        ctl1_r;
  item_kind_t        kind_nxt;
  logic              fault_nxt;
  logic signed [DIFF_W-1:0] d1_r, d2_r, d1_nxt, d2_nxt;
  logic [ACC_W-1:0]  sum1, sum2, rnd1, rnd2;
  logic              accept;
  logic              start_acc;
  logic              fault_now;

  function automatic logic out_of_range(input logic [ACC_W-1:0] off,
                                        input logic [CODE_W-1:0] mid,
                                        input logic [CODE_W-1:0] tol);
    logic signed [CMP_W-1:0] o, hi, lo;
    o  = signed'({2'b00, off});
    hi = signed'(CMP_W'(mid)) + signed'(CMP_W'(tol));
    lo = signed'(CMP_W'(mid)) - signed'(CMP_W'(tol));
    return (o > hi) || (o < lo);
  endfunction

  assign in_tready = !ctl1_r.valid || s1_take;
  assign accept    = in_tvalid && in_tready;
  assign start_acc = accept && (in_op == OP_START);

  assign sum1 = off1_r + ACC_W'(in_sample_first);
  assign sum2 = off2_r + ACC_W'(in_sample_second);
  assign rnd1 = (sum1 + ROUND_HALF) >> AVG_SHIFT;
  assign rnd2 = (sum2 + ROUND_HALF) >> AVG_SHIFT;

  assign fault_now = out_of_range(off1_r, midscale, tolerance) ||
                     out_of_range(off2_r, midscale, tolerance);

  assign d1_nxt = signed'({1'b0, in_sample_first}) - signed'({1'b0, off1_r[ADC_BITS-1:0]});
  assign d2_nxt = signed'({1'b0, in_sample_second}) - signed'({1'b0, off2_r[ADC_BITS-1:0]});

  always_comb begin
    busy_nxt  = busy_r;
    skip_nxt  = skip_r;
    cnt_nxt   = cnt_r;
    off1_nxt  = off1_r;
    off2_nxt  = off2_r;
    kind_nxt  = KIND_CAL;
    fault_nxt = 1'b0;
    priority if (in_op == OP_START) begin
      off1_nxt = '0;
      off2_nxt = '0;
      cnt_nxt  = CNT_INIT;
      skip_nxt = SKIP_INIT;
      busy_nxt = 1'b1;
    end else if (busy_r && (skip_r != '0)) begin
      skip_nxt = skip_r - 1'b1;
    end else if (busy_r && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - 1'b1;
      // The last pair of the window turns the sums into rounded averages.
      if (cnt_r == CNT_W'(1)) begin
        off1_nxt = rnd1;
        off2_nxt = rnd2;
      end else begin
        off1_nxt = sum1;
        off2_nxt = sum2;
      end
    end else if (busy_r) begin
      busy_nxt  = 1'b0;
      kind_nxt  = KIND_CLOSE;
      fault_nxt = fault_now;
    end else begin
      kind_nxt  = KIND_NORMAL;
      fault_nxt = fault_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      skip_r       <= '0;
      cnt_r        <= '0;
      off1_r       <= OFFSET_RST;
      off2_r       <= OFFSET_RST;
      ctl1_r.valid <= 1'b0;
    end else begin
      if (accept) begin
        busy_r       <= busy_nxt;
        skip_r       <= skip_nxt;
        cnt_r        <= cnt_nxt;
        off1_r       <= off1_nxt;
        off2_r       <= off2_nxt;
        ctl1_r.kind  <= kind_nxt;
        ctl1_r.fault <= fault_nxt;
      end
      if (in_tready) begin
        ctl1_r.valid <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d1_r <= d1_nxt;
      d2_r <= d2_nxt;
    end
  end

  assign ctl1        = ctl1_r;
  assign diff_first  = d1_r;
  assign diff_second = d2_r;

  `PCOC_ASSERT_IMP(a_idle_counters_clear, !busy_r, (skip_r == '0) && (cnt_r == '0))
  `PCOC_ASSERT_NEXT(a_start_loads, start_acc, busy_r && (skip_r == SKIP_INIT) && (cnt_r == CNT_INIT))
  `PCOC_ASSERT_IMP(a_skip_before_sum, busy_r && (skip_r != '0), cnt_r == CNT_INIT)

endmodule

[src/pcoc_conv.sv]
`include "phase_current_offset_calibrate_assert.svh"

module pcoc_conv #(
  parameter int ADC_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pcoc_pkg::stage_ctl_t                ctl1,
  input  logic signed [ADC_BITS:0]            diff_first,
  input  logic signed [ADC_BITS:0]            diff_second,
  input  logic signed [pcoc_pkg::GAIN_W-1:0]  gain,
  input  logic [1:0]                          phase_pair,
  output logic                                s1_take,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic                                calibrating,
  output logic                                currents_valid,
  output logic                                offset_fault,
  output logic signed [pcoc_pkg::CUR_W-1:0]   current_a,
  output logic signed [pcoc_pkg::CUR_W-1:0]   current_b,
  output logic signed [pcoc_pkg::CUR_W-1:0]   current_c
);
  import pcoc_pkg::*;

  localparam int PROD_W = ADC_BITS + 1 + GAIN_W;
  localparam int SH_W   = PROD_W - GAIN_SHIFT;
  localparam int SUM_W  = SH_W + 2;

  stage_ctl_t               ctl2_r;
  logic signed [PROD_W-1:0] p1_r, p2_r, p1_nxt, p2_nxt;
  logic signed [SH_W-1:0]   c1, c2;
  logic signed [SUM_W-1:0]  c3;
  logic signed [CUR_W-1:0]  s1, s2, s3;
  logic signed [CUR_W-1:0]  ia_nxt, ib_nxt, ic_nxt;
  logic                     en3;
  logic                     out_valid_r;
  logic                     cal_r, cv_r, fault_r;
  logic signed [CUR_W-1:0]  ia_r, ib_r, ic_r;

  assign en3     = !out_valid_r || out_tready;
  assign s1_take = !ctl2_r.valid || en3;

  assign p1_nxt = PROD_W'(diff_first) * PROD_W'(gain);
  assign p2_nxt = PROD_W'(diff_second) * PROD_W'(gain);

  // Floor shift of the products; the third phase is the negated sum.
  assign c1 = SH_W'(p1_r >>> GAIN_SHIFT);
  assign c2 = SH_W'(p2_r >>> GAIN_SHIFT);
  assign c3 = -(SUM_W'(c1) + SUM_W'(c2));

  assign s1 = sat_cur(SAT_IN_W'(c1));
  assign s2 = sat_cur(SAT_IN_W'(c2));
  assign s3 = sat_cur(SAT_IN_W'(c3));

  always_comb begin
    ia_nxt = '0;
    ib_nxt = '0;
    ic_nxt = '0;
    if (ctl2_r.kind == KIND_NORMAL) begin
      unique case (phase_pair)
        PAIR_AB: begin
          ia_nxt = s1;
          ib_nxt = s2;
          ic_nxt = s3;
        end
        PAIR_AC: begin
          ia_nxt = s1;
          ic_nxt = s2;
          ib_nxt = s3;
        end
        default: begin
          ib_nxt = s1;
          ic_nxt = s2;
          ia_nxt = s3;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r.valid <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (s1_take) begin
        ctl2_r.valid <= ctl1.valid;
      end
      if (s1_take && ctl1.valid) begin
        ctl2_r.kind  <= ctl1.kind;
        ctl2_r.fault <= ctl1.fault;
      end
      if (en3) begin
        out_valid_r <= ctl2_r.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && ctl1.valid) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
    if (en3 && ctl2_r.valid) begin
      cal_r   <= (ctl2_r.kind == KIND_CAL);
      cv_r    <= (ctl2_r.kind == KIND_NORMAL);
      fault_r <= ctl2_r.fault;
      ia_r    <= ia_nxt;
      ib_r    <= ib_nxt;
      ic_r    <= ic_nxt;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign calibrating    = cal_r;
  assign currents_valid = cv_r;
  assign offset_fault   = fault_r;
  assign current_a      = ia_r;
  assign current_b      = ib_r;
  assign current_c      = ic_r;

  `PCOC_ASSERT_IMP(a_flags_exclusive, out_valid_r, $onehot0({cal_r, cv_r}))
  `PCOC_ASSERT_IMP(a_no_fault_while_cal, out_valid_r && cal_r, !fault_r)

endmodule

[src/phase_current_offset_calibrate.sv]
// Two-phase current sense conversion with ADC offset calibration.
// Input channel in_*: one request per accepted beat. in_tuser is the opcode
// (start calibration or sample pair), in_tdata carries both ADC codes.
// Output channel out_*: exactly one result per request, in request order.
// out_tuser flags calibrating, currents_valid and offset_fault; out_tdata
// holds the three saturated phase currents.
// Configuration port cfg_*: a write lands on the edge where cfg_wr_en is
// high; registers are phase_pair, midscale, tolerance and gain.
// A request passes an input stage that updates the calibration counters and
// offsets, a multiply stage, and a saturate and phase-routing stage ending in
// the output register, which drives out_tvalid.
// Throughput is one request per cycle while out_tready is high.
// Synchronous reset clears the pipeline, restores the offsets to midscale
// and ends any calibration in progress. When out_tready is low the output
// register holds its result and the stages behind it keep filling until
// all three are occupied; only then does in_tready drop.
module phase_current_offset_calibrate #(
  parameter int ADC_BITS   = 12,
  parameter int AVG_SHIFT  = 7,
  parameter int SKIP_COUNT = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [0] op
  input  logic                                  in_tuser,
  // [ADC_BITS-1:0] sample_first, [2*ADC_BITS-1:ADC_BITS] sample_second
  input  logic [((2*ADC_BITS+7)/8)*8-1:0]       in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [0] calibrating, [1] currents_valid, [2] offset_fault
  output logic [2:0]                            out_tuser,
  // [15:0] current_a, [31:16] current_b, [47:32] current_c
  output logic [47:0]                           out_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [pcoc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [pcoc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import pcoc_pkg::*;

  logic [1:0]               phase_pair_r;
  logic [CODE_W-1:0]        midscale_r;
  logic [CODE_W-1:0]        tolerance_r;
  logic signed [GAIN_W-1:0] gain_r;

  stage_ctl_t               ctl1;
  logic signed [ADC_BITS:0] diff_first, diff_second;
  logic                     s1_take;
  logic                     calibrating, currents_valid, offset_fault;
  logic signed [CUR_W-1:0]  current_a, current_b, current_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_pair_r <= PAIR_RST;
      midscale_r   <= MIDSCALE_RST;
      tolerance_r  <= TOL_RST;
      gain_r       <= GAIN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_PHASE_PAIR: phase_pair_r <= cfg_wdata[1:0];
        REG_MIDSCALE:   midscale_r   <= cfg_wdata[CODE_W-1:0];
        REG_TOLERANCE:  tolerance_r  <= cfg_wdata[CODE_W-1:0];
        REG_GAIN:       gain_r       <= signed'(cfg_wdata[GAIN_W-1:0]);
        default:        ;
      endcase
    end
  end

  pcoc_cal #(
    .ADC_BITS   (ADC_BITS),
    .AVG_SHIFT  (AVG_SHIFT),
    .SKIP_COUNT (SKIP_COUNT)
  ) u_cal (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_op            (in_tuser),
    .in_sample_first  (in_tdata[ADC_BITS-1:0]),
    .in_sample_second (in_tdata[2*ADC_BITS-1:ADC_BITS]),
    .midscale         (midscale_r),
    .tolerance        (tolerance_r),
    .s1_take          (s1_take),
    .ctl1             (ctl1),
    .diff_first       (diff_first),
    .diff_second      (diff_second)
  );

  pcoc_conv #(
    .ADC_BITS (ADC_BITS)
  ) u_conv (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl1           (ctl1),
    .diff_first     (diff_first),
    .diff_second    (diff_second),
    .gain           (gain_r),
    .phase_pair     (phase_pair_r),
    .s1_take        (s1_take),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .calibrating    (calibrating),
    .currents_valid (currents_valid),
    .offset_fault   (offset_fault),
    .current_a      (current_a),
    .current_b      (current_b),
    .current_c      (current_c)
  );

  assign out_tuser = {offset_fault, currents_valid, calibrating};
  assign out_tdata = {current_c, current_b, current_a};

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import pcoc_pkg::*;

  localparam int SKIP_PAIRS     = 16;
  localparam int AVG_SHIFT      = 7;
  localparam int PIPE_LATENCY   = 3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 150;
  localparam int HOLD_AFTER     = 250;
  localparam int N_PHASES       = 8;
  localparam int N_DIR          = 13;
  localparam int CODE_MAX       = (1 << CODE_W) - 1;

  // The block treats this selector value like the B and C pair.
  localparam logic [1:0] PAIR_ALIAS_BC = 2'd3;

  typedef struct packed {
    logic                    calibrating;
    logic                    currents_valid;
    logic                    offset_fault;
    logic signed [CUR_W-1:0] ia;
    logic signed [CUR_W-1:0] ib;
    logic signed [CUR_W-1:0] ic;
  } sense_result_t;

  typedef struct {
    logic              op;
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] second;
    logic              typed;
    sense_result_t     want;
  } stim_row_t;

  localparam sense_result_t CAL_RESULT = '{1'b1, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic                  in_tuser = OP_SAMPLE;
  logic [23:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [2:0]            out_tuser;
  logic [47:0]           out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  phase_current_offset_calibrate uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Shadow of the block's registers and calibration state.
  logic [1:0]               sel_pair;
  logic [CODE_W-1:0]        mid_code;
  logic [CODE_W-1:0]        tol_code;
  logic signed [GAIN_W-1:0] gain_q12;
  int unsigned              off_first;
  int unsigned              off_second;
  int unsigned              skip_left;
  int unsigned              sum_left;
  logic                     cal_busy;

  sense_result_t pending_results [$];
  stim_row_t     dir_rows [0:N_DIR-1];

  // Side information travelling with the request being offered.
  logic          row_typed = 1'b0;
  sense_result_t row_want = '0;

  int burst_left = 0;
  int n_requests = 0;
  int n_starts = 0;
  int n_results = 0;
  int n_converted = 0;
  int n_faults = 0;
  int n_errors = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  int mode_left = 0;
  int ready_mode = 0;
  int tick = 0;
  bit long_hold_done = 1'b0;

  function automatic logic [CODE_W-1:0] rand_code();
    return CODE_W'($urandom);
  endfunction

  function automatic logic signed [CUR_W-1:0] clamp_current(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return CUR_W'(v);
  endfunction

  function automatic logic offset_out_of_window(int unsigned off);
    longint o;
    longint m;
    longint t;
    o = off;
    m = mid_code;
    t = tol_code;
    return (o > m + t) || (o < m - t);
  endfunction

  function automatic sense_result_t convert_request(logic op, logic [CODE_W-1:0] s1,
                                                    logic [CODE_W-1:0] s2);
    sense_result_t r;
    longint c1;
    longint c2;
    longint c3;
    r = '0;
    if (op == OP_START) begin
      off_first = 0;
      off_second = 0;
      skip_left = SKIP_PAIRS;
      sum_left = 1 << AVG_SHIFT;
      cal_busy = 1'b1;
      r.calibrating = 1'b1;
    end else if (cal_busy && skip_left > 0) begin
      skip_left--;
      r.calibrating = 1'b1;
    end else if (cal_busy && sum_left > 0) begin
      sum_left--;
      off_first += s1;
      off_second += s2;
      if (sum_left == 0) begin
        off_first = (off_first + (1 << (AVG_SHIFT - 1))) >> AVG_SHIFT;
        off_second = (off_second + (1 << (AVG_SHIFT - 1))) >> AVG_SHIFT;
      end
      r.calibrating = 1'b1;
    end else if (cal_busy) begin
      // The pair after the last summed one ends the calibration and reports the offset fault.
      cal_busy = 1'b0;
      r.offset_fault = offset_out_of_window(off_first) || offset_out_of_window(off_second);
    end else begin
      c1 = ((longint'(s1) - longint'(off_first)) * longint'(gain_q12)) >>> GAIN_SHIFT;
      c2 = ((longint'(s2) - longint'(off_second)) * longint'(gain_q12)) >>> GAIN_SHIFT;
      c3 = -(c1 + c2);
      case (sel_pair)
        PAIR_AB: begin
          r.ia = clamp_current(c1);
          r.ib = clamp_current(c2);
          r.ic = clamp_current(c3);
        end
        PAIR_AC: begin
          r.ia = clamp_current(c1);
          r.ic = clamp_current(c2);
          r.ib = clamp_current(c3);
        end
        default: begin
          r.ib = clamp_current(c1);
          r.ic = clamp_current(c2);
          r.ia = clamp_current(c3);
        end
      endcase
      r.currents_valid = 1'b1;
      r.offset_fault = offset_out_of_window(off_first) || offset_out_of_window(off_second);
    end
    return r;
  endfunction

  always @(posedge clk) begin : track_handshakes
    sense_result_t want;
    sense_result_t got;
    if (!rst_n) begin
      sel_pair = PAIR_RST;
      mid_code = MIDSCALE_RST;
      tol_code = TOL_RST;
      gain_q12 = GAIN_RST;
      off_first = 2048;
      off_second = 2048;
      skip_left = 0;
      sum_left = 0;
      cal_busy = 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_PHASE_PAIR: sel_pair = cfg_wdata[1:0];
          REG_MIDSCALE:   mid_code = cfg_wdata[CODE_W-1:0];
          REG_TOLERANCE:  tol_code = cfg_wdata[CODE_W-1:0];
          REG_GAIN:       gain_q12 = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want = convert_request(in_tuser, in_tdata[CODE_W-1:0], in_tdata[2*CODE_W-1:CODE_W]);
        pending_results.push_back(row_typed ? row_want : want);
        n_requests++;
        if (in_tuser == OP_START) n_starts++;
      end
      if (out_tvalid && out_tready) begin
        got.calibrating = out_tuser[0];
        got.currents_valid = out_tuser[1];
        got.offset_fault = out_tuser[2];
        got.ia = out_tdata[15:0];
        got.ib = out_tdata[31:16];
        got.ic = out_tdata[47:32];
        n_results++;
        if (got.currents_valid) n_converted++;
        if (got.offset_fault) n_faults++;
        if (pending_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("Unexpected result: cal=%b valid=%b fault=%b a=%0d b=%0d c=%0d",
                     got.calibrating, got.currents_valid, got.offset_fault,
                     got.ia, got.ib, got.ic);
        end else begin
          want = pending_results.pop_front();
          if (got.calibrating !== want.calibrating || got.currents_valid !== want.currents_valid
              || got.offset_fault !== want.offset_fault || got.ia !== want.ia
              || got.ib !== want.ib || got.ic !== want.ic) begin
            n_errors++;
            if (n_errors <= 10)
              $display({"Mismatch on result %0d: expected cal=%b valid=%b fault=%b ",
                        "a=%0d b=%0d c=%0d, got cal=%b valid=%b fault=%b a=%0d b=%0d c=%0d"},
                       n_results, want.calibrating, want.currents_valid, want.offset_fault,
                       want.ia, want.ib, want.ic, got.calibrating, got.currents_valid,
                       got.offset_fault, got.ia, got.ib, got.ic);
          end
        end
      end
    end
  end

  // Result side: changing stall modes, plus one long hold so the pipeline backs up.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!long_hold_done && n_results >= HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      tick++;
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= (tick % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(logic op, logic [CODE_W-1:0] s1, logic [CODE_W-1:0] s2,
                              logic typed, sense_result_t want);
    if (burst_left == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {s2, s1};
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  initial begin
    int c_first;
    int c_second;
    int spread;
    int v1;
    int v2;
    logic [1:0] new_pair;
    logic [CFG_DATA_W-1:0] new_mid;
    logic [CFG_DATA_W-1:0] new_tol;
    logic [CFG_DATA_W-1:0] new_gain;
    logic [CODE_W-1:0] a;
    logic [CODE_W-1:0] b;

    // Reset offsets sit at 2048 with unity gain, so these conversions are plain differences.
    dir_rows = '{
      '{OP_SAMPLE, 12'd2048, 12'd2048, 1'b1,
        '{1'b0, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0}},
      '{OP_SAMPLE, 12'd4095, 12'd0, 1'b1,
        '{1'b0, 1'b1, 1'b0, 16'sd2047, -16'sd2048, 16'sd1}},
      '{OP_SAMPLE, 12'd0, 12'd4095, 1'b1,
        '{1'b0, 1'b1, 1'b0, -16'sd2048, 16'sd2047, 16'sd1}},
      '{OP_SAMPLE, 12'd0, 12'd0, 1'b1,
        '{1'b0, 1'b1, 1'b0, -16'sd2048, -16'sd2048, 16'sd4096}},
      '{OP_SAMPLE, 12'd4095, 12'd4095, 1'b1,
        '{1'b0, 1'b1, 1'b0, 16'sd2047, 16'sd2047, -16'sd4094}},
      '{OP_SAMPLE, 12'hA5A, 12'h5A5, 1'b0, '0},
      '{OP_SAMPLE, 12'h123, 12'hEDC, 1'b0, '0},
      '{OP_START, 12'hFFF, 12'hFFF, 1'b1, CAL_RESULT},
      '{OP_SAMPLE, 12'd4095, 12'd4095, 1'b1, CAL_RESULT},
      '{OP_SAMPLE, 12'd0, 12'd0, 1'b1, CAL_RESULT},
      '{OP_START, 12'd0, 12'd0, 1'b1, CAL_RESULT},
      '{OP_SAMPLE, 12'h800, 12'h7FF, 1'b1, CAL_RESULT},
      '{OP_SAMPLE, 12'd1, 12'd2, 1'b1, CAL_RESULT}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++)
      send_request(dir_rows[i].op, dir_rows[i].first, dir_rows[i].second,
                   dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          new_pair = PAIR_RST;
          new_mid = CFG_DATA_W'(MIDSCALE_RST);
          new_tol = CFG_DATA_W'(TOL_RST);
          new_gain = GAIN_RST;
        end
        1: begin
          new_pair = PAIR_AC;
          new_mid = '0;
          new_tol = '0;
          new_gain = 16'h8000;
        end
        2: begin
          new_pair = PAIR_BC;
          new_mid = CFG_DATA_W'(CODE_MAX);
          new_tol = CFG_DATA_W'(CODE_MAX);
          new_gain = 16'h7FFF;
        end
        3: begin
          new_pair = PAIR_ALIAS_BC;
          new_mid = CFG_DATA_W'(MIDSCALE_RST);
          new_tol = '0;
          new_gain = -16'sd4096;
        end
        default: begin
          new_pair = 2'($urandom_range(0, 3));
          new_mid = CFG_DATA_W'(rand_code());
          new_tol = CFG_DATA_W'($urandom_range(0, 400));
          new_gain = CFG_DATA_W'($urandom);
        end
      endcase
      write_reg(REG_PHASE_PAIR, CFG_DATA_W'(new_pair));
      write_reg(REG_MIDSCALE, new_mid);
      write_reg(REG_TOLERANCE, new_tol);
      write_reg(REG_GAIN, new_gain);
      @(negedge clk);
      cfg_wr_en <= 1'b0;

      // Odd phases keep the previous offsets, so a midscale change must not move them.
      if (ph % 2 == 0) begin
        case (ph)
          0: begin
            c_first = 1948 + $urandom_range(0, 200);
            c_second = 1948 + $urandom_range(0, 200);
            spread = 300;
          end
          2: begin
            c_first = $urandom_range(0, CODE_MAX);
            c_second = $urandom_range(0, CODE_MAX);
            spread = 1000;
            // A calibration cut short by a fresh start.
            send_request(OP_START, rand_code(), rand_code(), 1'b0, '0);
            repeat ($urandom_range(1, 150))
              send_request(OP_SAMPLE, rand_code(), rand_code(), 1'b0, '0);
          end
          4: begin
            c_first = 0;
            c_second = CODE_MAX;
            spread = 0;
          end
          default: begin
            c_first = $urandom_range(1800, 2300);
            c_second = $urandom_range(1800, 2300);
            spread = 60;
          end
        endcase
        send_request(OP_START, rand_code(), rand_code(), 1'b0, '0);
        repeat (SKIP_PAIRS) send_request(OP_SAMPLE, rand_code(), rand_code(), 1'b0, '0);
        repeat (1 << AVG_SHIFT) begin
          v1 = c_first + int'($urandom_range(0, 2 * spread)) - spread;
          v2 = c_second + int'($urandom_range(0, 2 * spread)) - spread;
          v1 = (v1 < 0) ? 0 : ((v1 > CODE_MAX) ? CODE_MAX : v1);
          v2 = (v2 < 0) ? 0 : ((v2 > CODE_MAX) ? CODE_MAX : v2);
          send_request(OP_SAMPLE, CODE_W'(v1), CODE_W'(v2), 1'b0, '0);
        end
        send_request(OP_SAMPLE, rand_code(), rand_code(), 1'b0, '0);
      end

      repeat ($urandom_range(40, 60)) begin
        a = rand_code();
        b = rand_code();
        if ($urandom_range(0, 7) == 0) a = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? '1 : '0;
        send_request(OP_SAMPLE, a, b, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (pending_results.size() != 0) n_errors++;
    $display("Ran %0d requests over %0d register settings, %0d of them calibration starts.",
             n_requests, N_PHASES, n_starts);
    $display("Checked %0d results: %0d conversions, %0d with offset fault, %0d mismatches.",
             n_results, n_converted, n_faults, n_errors);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
